// File: src/bsfr_pkg.sv
// Package for the byte-stuffed frame receiver.
// Holds result kinds, configuration register indexes, reset values and the result type.
// Used by byte_stuffed_frame_receiver_unit and bsfr_checker.
package bsfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 12;
  localparam int unsigned LenW   = 13;
  localparam int unsigned CfgIdW = 2;

  localparam logic [LenW-1:0] MaxFrame = LenW'(4096);

  localparam logic [ByteW-1:0] StartReset  = 8'h03;
  localparam logic [ByteW-1:0] EndReset    = 8'h10;
  localparam logic [ByteW-1:0] EscapeReset = 8'h02;
  localparam logic [LenW-1:0]  MaxLenReset = LenW'(4096);

  localparam logic [CfgIdW-1:0] CfgStartCode  = 2'd0;
  localparam logic [CfgIdW-1:0] CfgEndCode    = 2'd1;
  localparam logic [CfgIdW-1:0] CfgEscapeCode = 2'd2;
  localparam logic [CfgIdW-1:0] CfgMaxLength  = 2'd3;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_START = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  out_byte;
    logic [IndexW-1:0] byte_index;
    logic [LenW-1:0]   frame_length;
  } result_t;

endpackage

// File: src/byte_stuffed_frame_receiver_unit.sv
// Byte-stuffed frame receiver: deframes escaped bytes, checks XOR checksum.
// Single-pass datapath with a two-entry output register (main + skid).
// Depends on bsfr_pkg.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid_i, in_stall_o, rx_byte_i    | receive
//   out     | out_valid_o, out_stall_i, kind_o,    | send
//           | out_byte_o, byte_index_o,            |
//           | frame_length_o                       |
//   cfg     | cfg_we_i, cfg_index_i, cfg_data_i    | receive
//
// One transaction per cycle while in_stall_o is low; each result is registered in the main or skid entry.
// The frame state update (compare, XOR, count) is combinational and registered on each accepted input.
// Reset clears frame state and the output valid flags and loads default codes.
// in_stall_o rises only when both output entries hold results.
module byte_stuffed_frame_receiver_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bsfr_pkg::ByteW-1:0]    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [bsfr_pkg::ByteW-1:0]    out_byte_o,
  output logic [bsfr_pkg::IndexW-1:0]   byte_index_o,
  output logic [bsfr_pkg::LenW-1:0]     frame_length_o,
  input  logic                          cfg_we_i,
  input  logic [bsfr_pkg::CfgIdW-1:0]   cfg_index_i,
  input  logic [bsfr_pkg::LenW-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RECV = 2'd1,
    MODE_ESC  = 2'd2
  } mode_e;

  logic [bsfr_pkg::ByteW-1:0] start_code_q, end_code_q, escape_code_q;
  logic [bsfr_pkg::LenW-1:0]  max_len_q;

  mode_e                      mode_q, mode_d;
  logic [bsfr_pkg::LenW-1:0]  fill_q, fill_d;
  logic [bsfr_pkg::ByteW-1:0] xor_q, xor_d;
  logic                       held_vld_q, held_vld_d;
  logic [bsfr_pkg::ByteW-1:0] held_q, held_d;

  bsfr_pkg::result_t res_d, out_q, skid_q;
  logic              res_vld_d, out_vld_q, skid_vld_q;

  logic [bsfr_pkg::LenW-1:0] limit;
  logic                      in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_vld_q && !out_stall_i;
  assign in_stall_o = skid_vld_q;
  assign limit = (max_len_q > bsfr_pkg::MaxFrame) ? bsfr_pkg::MaxFrame : max_len_q;

  always_comb begin
    logic take, over;
    take       = 1'b0;
    mode_d     = mode_q;
    fill_d     = fill_q;
    xor_d      = xor_q;
    held_vld_d = held_vld_q;
    held_d     = held_q;
    res_vld_d  = 1'b0;
    res_d      = '0;
    res_d.kind = bsfr_pkg::KIND_DATA;

    unique case (mode_q)
      MODE_ESC: begin
        take = 1'b1;
      end
      MODE_RECV: begin
        priority if (rx_byte_i == escape_code_q) begin
          mode_d = MODE_ESC;
        end else if (rx_byte_i == start_code_q) begin
          fill_d     = '0;
          xor_d      = '0;
          held_vld_d = 1'b0;
          res_vld_d  = 1'b1;
          res_d.kind = bsfr_pkg::KIND_START;
        end else if (rx_byte_i == end_code_q) begin
          mode_d             = MODE_IDLE;
          res_vld_d          = 1'b1;
          res_d.kind         = (held_vld_q && held_q == xor_q) ?
                               bsfr_pkg::KIND_GOOD : bsfr_pkg::KIND_BAD;
          res_d.frame_length = fill_q;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        if (rx_byte_i == start_code_q) begin
          mode_d     = MODE_RECV;
          fill_d     = '0;
          xor_d      = '0;
          held_vld_d = 1'b0;
          res_vld_d  = 1'b1;
          res_d.kind = bsfr_pkg::KIND_START;
        end
      end
    endcase

    over = fill_q >= limit;
    if (take) begin
      if (over) begin
        // silent restart; an escaping receiver stays escaping
        fill_d     = '0;
        xor_d      = '0;
        held_vld_d = 1'b0;
      end else begin
        mode_d = MODE_RECV;
        held_d = rx_byte_i;
        if (held_vld_q) begin
          res_vld_d        = 1'b1;
          res_d.out_byte   = held_q;
          res_d.byte_index = fill_q[bsfr_pkg::IndexW-1:0];
          fill_d           = fill_q + bsfr_pkg::LenW'(1);
          xor_d            = xor_q ^ held_q;
        end else begin
          held_vld_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q  <= bsfr_pkg::StartReset;
      end_code_q    <= bsfr_pkg::EndReset;
      escape_code_q <= bsfr_pkg::EscapeReset;
      max_len_q     <= bsfr_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bsfr_pkg::CfgStartCode:  start_code_q  <= cfg_data_i[bsfr_pkg::ByteW-1:0];
        bsfr_pkg::CfgEndCode:    end_code_q    <= cfg_data_i[bsfr_pkg::ByteW-1:0];
        bsfr_pkg::CfgEscapeCode: escape_code_q <= cfg_data_i[bsfr_pkg::ByteW-1:0];
        bsfr_pkg::CfgMaxLength:  max_len_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      fill_q     <= '0;
      xor_q      <= '0;
      held_vld_q <= 1'b0;
      held_q     <= '0;
    end else if (in_acc) begin
      mode_q     <= mode_d;
      fill_q     <= fill_d;
      xor_q      <= xor_d;
      held_vld_q <= held_vld_d;
      held_q     <= held_d;
    end
  end

  // main output entry plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (in_acc && res_vld_d && out_vld_q && out_stall_i) begin
        skid_vld_q <= 1'b1;
      end else if (out_acc) begin
        skid_vld_q <= 1'b0;
      end
      if (out_acc) begin
        out_vld_q <= skid_vld_q || (in_acc && res_vld_d);
      end else if (!out_vld_q) begin
        out_vld_q <= in_acc && res_vld_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_vld_d && out_vld_q && out_stall_i) begin
      skid_q <= res_d;
    end
    if (out_acc && skid_vld_q) begin
      out_q <= skid_q;
    end else if ((out_acc || !out_vld_q) && in_acc && res_vld_d) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign kind_o         = out_q.kind;
  assign out_byte_o     = out_q.out_byte;
  assign byte_index_o   = out_q.byte_index;
  assign frame_length_o = out_q.frame_length;

endmodule

// File: src/bsfr_checker.sv
// Port-level checker for byte_stuffed_frame_receiver_unit, bound into that module.
// Depends on bsfr_pkg.
module bsfr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  kind_o,
  input logic [bsfr_pkg::ByteW-1:0]  out_byte_o,
  input logic [bsfr_pkg::IndexW-1:0] byte_index_o,
  input logic [bsfr_pkg::LenW-1:0]   frame_length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(out_byte_o)
      && $stable(byte_index_o) && $stable(frame_length_o))
    else $error("stalled output transaction changed");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == bsfr_pkg::KIND_DATA |-> frame_length_o == '0)
    else $error("payload transaction carries a frame length");

  a_ctrl_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != bsfr_pkg::KIND_DATA |->
      out_byte_o == '0 && byte_index_o == '0
      && (kind_o != bsfr_pkg::KIND_START || frame_length_o == '0)
      && frame_length_o <= bsfr_pkg::MaxFrame)
    else $error("frame event transaction has bad fields");

endmodule

bind byte_stuffed_frame_receiver_unit bsfr_checker u_bsfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_o         (kind_o),
  .out_byte_o     (out_byte_o),
  .byte_index_o   (byte_index_o),
  .frame_length_o (frame_length_o)
);

// File: tb/testbench.sv
// Self-checking testbench for byte_stuffed_frame_receiver_unit.
// Mirrors the deframer state in SV, drives byte streams with random idling and stalls.
// Depends on bsfr_pkg and byte_stuffed_frame_receiver_unit.
module testbench;
  import bsfr_pkg::*;

  localparam int WatchdogLimit = 3000;

  typedef enum logic [1:0] {
    RX_IDLE  = 2'd0,
    RX_FRAME = 2'd1,
    RX_ESC   = 2'd2
  } rx_mode_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [ByteW-1:0]  rx_byte_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        kind_o;
  logic [ByteW-1:0]  out_byte_o;
  logic [IndexW-1:0] byte_index_o;
  logic [LenW-1:0]   frame_length_o;
  logic              cfg_we_i    = 1'b0;
  logic [CfgIdW-1:0] cfg_index_i = '0;
  logic [LenW-1:0]   cfg_data_i  = '0;

  byte_stuffed_frame_receiver_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .out_byte_o     (out_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // register mirror
  logic [ByteW-1:0] cfg_start   = StartReset;
  logic [ByteW-1:0] cfg_end     = EndReset;
  logic [ByteW-1:0] cfg_esc     = EscapeReset;
  logic [LenW-1:0]  cfg_max_len = MaxLenReset;

  // deframer mirror
  rx_mode_e         rx_mode   = RX_IDLE;
  logic [LenW-1:0]  fill_cnt  = '0;
  logic [ByteW-1:0] frame_xor = '0;
  logic             held_vld  = 1'b0;
  logic [ByteW-1:0] held_b    = '0;

  result_t expected_results[$];
  int      error_count      = 0;
  int      sent_count       = 0;
  int      quiet_cycles     = 0;
  int      sink_hold_cycles = 0;
  bit      send_idle_on     = 1'b1;
  bit      recv_idle_on     = 1'b1;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_frame();
    fill_cnt  = '0;
    held_vld  = 1'b0;
    frame_xor = '0;
  endfunction

  // -1: overflow restart, 0: byte held, 1: payload result
  function automatic int take_payload(input logic [ByteW-1:0] b, inout result_t r);
    logic [LenW-1:0] lim;
    lim = (cfg_max_len > MaxFrame) ? MaxFrame : cfg_max_len;
    if (fill_cnt >= lim) begin
      clear_frame();
      return -1;
    end
    if (held_vld) begin
      r.kind       = KIND_DATA;
      r.out_byte   = held_b;
      r.byte_index = fill_cnt[IndexW-1:0];
      fill_cnt     = fill_cnt + LenW'(1);
      frame_xor    = frame_xor ^ held_b;
      held_b       = b;
      return 1;
    end
    held_b   = b;
    held_vld = 1'b1;
    return 0;
  endfunction

  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output result_t r);
    int n;
    r = '0;
    case (rx_mode)
      RX_ESC: begin
        n = take_payload(b, r);
        if (n < 0) return 1'b0;
        rx_mode = RX_FRAME;
        return n == 1;
      end
      RX_FRAME: begin
        if (b == cfg_esc) begin
          rx_mode = RX_ESC;
          return 1'b0;
        end
        if (b == cfg_start) begin
          clear_frame();
          r.kind = KIND_START;
          return 1'b1;
        end
        if (b == cfg_end) begin
          rx_mode        = RX_IDLE;
          r.kind         = (held_vld && held_b == frame_xor) ? KIND_GOOD : KIND_BAD;
          r.frame_length = fill_cnt;
          return 1'b1;
        end
        n = take_payload(b, r);
        return n == 1;
      end
      default: begin
        rx_mode = RX_IDLE;
        if (b == cfg_start) begin
          clear_frame();
          rx_mode = RX_FRAME;
          r.kind  = KIND_START;
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // Leaves valid high; the caller's next send or drain takes over in the same step.
  task automatic send_raw_byte(input logic [ByteW-1:0] b);
    int      gap;
    result_t r;
    gap = send_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (deframe_byte(b, r)) expected_results.push_back(r);
    sent_count++;
  endtask

  task automatic send_payload_byte(input logic [ByteW-1:0] b);
    if (b == cfg_esc || b == cfg_start || b == cfg_end || $urandom_range(0, 15) == 0)
      send_raw_byte(cfg_esc);
    send_raw_byte(b);
  endtask

  task automatic send_frame(input int len, input bit bad_sum);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    send_raw_byte(cfg_start);
    sum = '0;
    for (int i = 0; i < len; i++) begin
      b   = ByteW'($urandom);
      sum = sum ^ b;
      send_payload_byte(b);
    end
    if (bad_sum) sum = sum ^ ByteW'(1 << $urandom_range(0, 7));
    send_payload_byte(sum);
    send_raw_byte(cfg_end);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_codes(input logic [ByteW-1:0] s, input logic [ByteW-1:0] e,
                             input logic [ByteW-1:0] x, input logic [LenW-1:0] m);
    logic [CfgIdW-1:0] idx[4];
    logic [LenW-1:0]   val[4];
    idx = '{CfgStartCode, CfgEndCode, CfgEscapeCode, CfgMaxLength};
    val = '{LenW'(s), LenW'(e), LenW'(x), m};
    drain_results();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b0;
    cfg_start   = s;
    cfg_end     = e;
    cfg_esc     = x;
    cfg_max_len = m;
  endtask

  task automatic send_sequence(input logic [ByteW-1:0] seq[]);
    foreach (seq[i]) send_raw_byte(seq[i]);
  endtask

  task automatic test_reset_codes();
    // idle noise, escaped codes, end without checksum, restart, bad and good sums
    send_sequence('{8'h10, 8'h02, 8'h00, 8'hFF,
                    8'h03, 8'h00, 8'hFF, 8'h02, 8'h02, 8'h02, 8'h03, 8'h02, 8'h10,
                    8'hEE, 8'h10,
                    8'h03, 8'h10,
                    8'h03, 8'h41, 8'h03, 8'h5A, 8'h10,
                    8'h03, 8'h00, 8'h10});
  endtask

  task automatic test_length_limit();
    write_codes(8'h00, 8'hFF, 8'h7E, LenW'(1));
    // overflow while escaping keeps the escape
    send_sequence('{8'h00, 8'h11, 8'h22, 8'h7E, 8'h33, 8'hFF, 8'hFF});
    write_codes(8'h00, 8'hFF, 8'h7E, LenW'(0));
    send_sequence('{8'h00, 8'h11, 8'h22, 8'hFF});
    write_codes(8'h55, 8'h55, 8'h55, MaxLenReset);
    send_sequence('{8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55});
    write_codes(8'hFF, 8'h00, 8'hFF, MaxLenReset);
    send_sequence('{8'hFF, 8'h12, 8'hFF, 8'h00, 8'h12, 8'h00});
  endtask

  task automatic test_backpressure();
    write_codes(StartReset, EndReset, EscapeReset, MaxLenReset);
    send_idle_on     = 1'b0;
    sink_hold_cycles = 400;
    repeat (6) send_frame(6, 1'b0);
    drain_results();
    send_idle_on = 1'b1;
    repeat (3) send_frame($urandom_range(1, 5), 1'b0);
  endtask

  task automatic test_long_frame();
    write_codes(StartReset, EndReset, EscapeReset, MaxLenReset);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    send_frame(40, 1'b0);
    // limit above the frame size is clamped
    write_codes(StartReset, EndReset, EscapeReset, LenW'(8191));
    send_raw_byte(cfg_start);
    repeat (40) send_payload_byte(ByteW'($urandom));
    send_raw_byte(cfg_end);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int               target;
    int               phase_end;
    int               lim;
    logic [ByteW-1:0] s, e, x;
    target = sent_count + 1250;
    while (sent_count < target) begin
      case ($urandom_range(0, 3))
        0: begin s = StartReset; e = EndReset; x = EscapeReset; end
        1: begin s = ByteW'($urandom); e = ByteW'($urandom); x = ByteW'($urandom); end
        2: begin
          s = ByteW'($urandom);
          e = s + ByteW'($urandom_range(1, 127));
          x = e + ByteW'($urandom_range(1, 127));
        end
        default: begin
          s = ByteW'($urandom);
          e = $urandom_range(0, 1) ? s : ByteW'($urandom);
          x = $urandom_range(0, 1) ? s : e;
        end
      endcase
      write_codes(s, e, x,
                  ($urandom_range(0, 3) == 0) ? MaxLenReset : LenW'($urandom_range(1, 24)));
      send_idle_on = $urandom_range(0, 2) != 0;
      recv_idle_on = $urandom_range(0, 2) != 0;
      lim = (cfg_max_len > MaxFrame) ? MaxFrame : cfg_max_len;
      phase_end = sent_count + $urandom_range(80, 200);
      while (sent_count < phase_end && sent_count < target) begin
        case ($urandom_range(0, 9))
          6: repeat ($urandom_range(1, 4)) send_raw_byte(ByteW'($urandom));
          7: begin
            send_raw_byte(cfg_start);
            repeat ($urandom_range(0, 4)) send_payload_byte(ByteW'($urandom));
            if ($urandom_range(0, 1)) send_raw_byte(cfg_esc);
          end
          8: begin
            if (lim <= 30) send_frame(lim + $urandom_range(0, 3), 1'b0);
            else send_frame($urandom_range(0, 10), 1'b0);
          end
          9: begin
            send_raw_byte(cfg_start);
            if ($urandom_range(0, 1)) send_raw_byte(cfg_esc);
            send_raw_byte(cfg_end);
            send_raw_byte(cfg_end);
          end
          default: send_frame($urandom_range(0, 10), $urandom_range(0, 3) == 0);
        endcase
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_codes();
    test_length_limit();
    test_backpressure();
    test_long_frame();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** byte_stuffed_frame_receiver_unit: PASSED **");
    end else begin
      $display("** byte_stuffed_frame_receiver_unit: FAILED **");
    end
    $finish;
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles > 0) begin
        n = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        n = recv_idle_on ? $urandom_range(0, 16) : 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    result_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: kind %0d", kind_o);
        error_count++;
      end else begin
        exp = expected_results.pop_front();
        if (kind_o !== exp.kind) begin
          $error("kind: expected %0d, got %0d", exp.kind, kind_o);
          error_count++;
        end
        if (out_byte_o !== exp.out_byte) begin
          $error("out_byte: expected %0h, got %0h", exp.out_byte, out_byte_o);
          error_count++;
        end
        if (byte_index_o !== exp.byte_index) begin
          $error("byte_index: expected %0d, got %0d", exp.byte_index, byte_index_o);
          error_count++;
        end
        if (frame_length_o !== exp.frame_length) begin
          $error("frame_length: expected %0d, got %0d", exp.frame_length, frame_length_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("** byte_stuffed_frame_receiver_unit: FAILED **");
      $finish;
    end
  end

endmodule
